// ===== sv/fwhb_pkg.sv =====
// Shared types, constants and CRC functions for the firmware image header builder.
package fwhb_pkg;

   // CRC-32, reflected form
   localparam logic [31:0] CRC_POLY     = 32'hEDB8_8320;
   localparam logic [31:0] ALL_ONES     = 32'hFFFF_FFFF;

   // Vector table address windows
   localparam logic [31:0] SRAM_MASK    = 32'h2FFE_0000;
   localparam logic [31:0] SRAM_BASE    = 32'h2000_0000;
   localparam logic [31:0] FLASH_MASK   = 32'hFF00_0000;
   localparam logic [31:0] FLASH_BASE   = 32'h0800_0000;

   // Header layout
   localparam logic [15:0] HDR_BYTES    = 16'd32;
   localparam logic [31:0] MIN_IMAGE    = 32'd8;
   localparam logic [2:0]  LAST_WORD    = 3'd7;

   // Depth of the job queue between front and back
   localparam int unsigned JOB_QUEUE_DEPTH = 2;

   // Register indexes of the csr port
   localparam int unsigned CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_MAGIC      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HDR_VER    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_APP_VER    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_KIND = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_LOAD_ADDR  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_LIMIT = 3'd5;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_TOO_LARGE = 3'd1,
      ST_TOO_SMALL = 3'd2,
      ST_BAD_STACK = 3'd3,
      ST_BAD_RESET = 3'd4
   } status_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [31:0] header_word;
      logic [2:0]  word_index;
      logic        final_word;
      logic [2:0]  status;
   } rsp_type;

   typedef struct packed {
      logic [31:0] package_magic;
      logic [15:0] header_format_version;
      logic [31:0] application_version;
      logic [31:0] image_kind;
      logic [31:0] load_address;
      logic [31:0] size_limit;
   } cfg_type;

   // One finished image, handed from front to back
   typedef struct packed {
      status_type  status;
      logic [31:0] byte_len;
      logic [31:0] image_crc;
   } job_type;

   // One byte through the reflected CRC; flattens to an XOR network
   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'd0, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

   // Four bytes, least significant first
   function automatic logic [31:0] crc_word(input logic [31:0] crc, input logic [31:0] w);
      logic [31:0] c;
      c = crc;
      for (int k = 0; k < 4; k++) begin
         c = crc_byte(c, w[k*8 +: 8]);
      end
      return c;
   endfunction

endpackage

// ===== sv/fwhb_front.sv =====
// Front end: per-byte CRC, byte count, vector capture and image validation.
module fwhb_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_accept,
   input  fwhb_pkg::req_type req_data,
   input  logic [31:0]       size_limit,
   output logic              job_push,
   output fwhb_pkg::job_type job
);
   import fwhb_pkg::*;

   logic [31:0] crc_ff, crc_in;
   logic [31:0] count_ff, count_in;
   logic [31:0] stack_ff, stack_in;
   logic [31:0] rvec_ff, rvec_in;

   logic [31:0] crc_nxt, count_nxt, stack_nxt, rvec_nxt;
   logic [31:0] byte_shifted;
   status_type  status;

   // Running image state after the current byte
   always_comb begin
      byte_shifted = {24'd0, req_data.data_byte} << {count_ff[1:0], 3'b000};
      crc_nxt   = crc_byte(crc_ff, req_data.data_byte);
      count_nxt = (count_ff == ALL_ONES) ? count_ff : count_ff + 32'd1;
      stack_nxt = stack_ff;
      rvec_nxt  = rvec_ff;
      if (count_ff < 32'd4) begin
         stack_nxt = stack_ff | byte_shifted;
      end else if (count_ff < MIN_IMAGE) begin
         rvec_nxt = rvec_ff | byte_shifted;
      end
   end

   // Validation, first failing check wins
   always_comb begin
      if (count_nxt > size_limit) begin
         status = ST_TOO_LARGE;
      end else if (count_nxt < MIN_IMAGE) begin
         status = ST_TOO_SMALL;
      end else if ((stack_nxt & SRAM_MASK) != SRAM_BASE) begin
         status = ST_BAD_STACK;
      end else if ((rvec_nxt & FLASH_MASK) != FLASH_BASE) begin
         status = ST_BAD_RESET;
      end else begin
         status = ST_OK;
      end
   end

   assign job_push       = req_accept & req_data.last_byte;
   assign job.status     = status;
   assign job.byte_len   = count_nxt;
   assign job.image_crc  = crc_nxt ^ ALL_ONES;

   // State clears after the last byte of each image
   always_comb begin
      crc_in   = crc_ff;
      count_in = count_ff;
      stack_in = stack_ff;
      rvec_in  = rvec_ff;
      if (req_accept) begin
         if (req_data.last_byte) begin
            crc_in   = ALL_ONES;
            count_in = '0;
            stack_in = '0;
            rvec_in  = '0;
         end else begin
            crc_in   = crc_nxt;
            count_in = count_nxt;
            stack_in = stack_nxt;
            rvec_in  = rvec_nxt;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff   <= ALL_ONES;
         count_ff <= '0;
         stack_ff <= '0;
         rvec_ff  <= '0;
      end else begin
         crc_ff   <= crc_in;
         count_ff <= count_in;
         stack_ff <= stack_in;
         rvec_ff  <= rvec_in;
      end
   end

endmodule

// ===== sv/fwhb_queue.sv =====
// Short job queue between the front end and the header emitter.
module fwhb_queue #(
   parameter int unsigned DEPTH = fwhb_pkg::JOB_QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_en,
   input  fwhb_pkg::job_type push_job,
   input  logic              pop_en,
   output fwhb_pkg::job_type pop_job,
   output logic              q_full,
   output logic              q_valid
);
   import fwhb_pkg::*;

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   job_type          slot_ff [DEPTH];
   logic [PTR_W-1:0] wptr_ff, wptr_in;
   logic [PTR_W-1:0] rptr_ff, rptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign q_full  = (count_ff == CNT_FULL);
   assign q_valid = (count_ff != '0);
   assign do_push = push_en & ~q_full;
   assign do_pop  = pop_en & q_valid;
   assign pop_job = slot_ff[rptr_ff];

   // Pointer and occupancy update
   always_comb begin
      wptr_in  = wptr_ff;
      rptr_in  = rptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wptr_in = (wptr_ff == PTR_LAST) ? '0 : wptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rptr_in = (rptr_ff == PTR_LAST) ? '0 : rptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   // Payload slots
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wptr_ff] <= push_job;
      end
   end

endmodule

// ===== sv/fwhb_back.sv =====
// Back end: emits one error word or the eight header words per job.
module fwhb_back (
   input  logic              clock,
   input  logic              reset,
   input  fwhb_pkg::cfg_type cfg,
   input  logic              job_valid,
   input  fwhb_pkg::job_type job,
   output logic              job_pop,
   input  logic              pop,
   output logic              empty,
   output fwhb_pkg::rsp_type rsp_data
);
   import fwhb_pkg::*;

   logic        busy_ff, busy_in;
   job_type     job_ff, job_in;
   logic [2:0]  idx_ff, idx_in;
   logic [31:0] hc_ff, hc_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff, rsp_in;

   logic        advance, emit, done, is_err;
   logic [31:0] word;

   assign advance = ~rsp_valid_ff | pop;
   assign emit    = advance & busy_ff;
   assign is_err  = (job_ff.status != ST_OK);
   assign done    = emit & (is_err | (idx_ff == LAST_WORD));
   assign job_pop = job_valid & (~busy_ff | done);

   // Header word at the current position
   always_comb begin
      case (idx_ff)
         3'd0:    word = cfg.package_magic;
         3'd1:    word = {cfg.header_format_version, HDR_BYTES};
         3'd2:    word = cfg.application_version;
         3'd3:    word = job_ff.byte_len;
         3'd4:    word = job_ff.image_crc;
         3'd5:    word = cfg.load_address;
         3'd6:    word = cfg.image_kind;
         3'd7:    word = hc_ff ^ ALL_ONES;
         default: word = '0;
      endcase
   end

   // Sequencing and output register
   always_comb begin
      busy_in      = busy_ff;
      job_in       = job_ff;
      idx_in       = idx_ff;
      hc_in        = hc_ff;
      rsp_valid_in = rsp_valid_ff & ~pop;
      rsp_in       = rsp_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         if (is_err) begin
            rsp_in.header_word = '0;
            rsp_in.word_index  = '0;
            rsp_in.final_word  = 1'b1;
            rsp_in.status      = job_ff.status;
         end else begin
            rsp_in.header_word = word;
            rsp_in.word_index  = idx_ff;
            rsp_in.final_word  = (idx_ff == LAST_WORD);
            rsp_in.status      = ST_OK;
         end
         idx_in = idx_ff + 3'd1;
         hc_in  = crc_word(hc_ff, word);
      end
      if (done) begin
         busy_in = 1'b0;
      end
      if (job_pop) begin
         busy_in = 1'b1;
         job_in  = job;
         idx_in  = '0;
         hc_in   = ALL_ONES;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
         idx_ff       <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
      hc_ff  <= hc_in;
      rsp_ff <= rsp_in;
   end

   assign empty    = ~rsp_valid_ff;
   assign rsp_data = rsp_ff;

   // A passing header streams without gaps once its words are taken
   a_word_follows: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && pop && !rsp_ff.final_word) |=>
         (rsp_valid_ff && rsp_ff.word_index == $past(rsp_ff.word_index) + 3'd1))
      else $error("header word missing or out of order");

   // Error transactions carry a single zero word
   a_error_shape: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.status != ST_OK) |->
         (rsp_ff.final_word && rsp_ff.word_index == '0 && rsp_ff.header_word == '0))
      else $error("malformed error transaction");

   // A passing header ends only at its last word
   a_final_position: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.status == ST_OK) |->
         (rsp_ff.final_word == (rsp_ff.word_index == LAST_WORD)))
      else $error("final flag on wrong header word");

   // No new job is taken while one is in flight
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && !done) |-> !job_pop)
      else $error("job taken while emitter busy");

endmodule

// ===== sv/firmware_image_header_builder.sv =====
// Top level: csr registers, byte front end, job queue and header emitter.
//
//   channel   handshake            payload
//   ------    ---------            -------
//   request   push / full          req_data  (data_byte, last_byte)
//   response  pop / empty          rsp_data  (header_word, word_index, final_word, status)
//   csr       csr_we               csr_index, csr_wdata
//
// The front end takes one byte per cycle unless full; the CRC update is one byte-wide XOR
// network. On the last byte a job enters a QUEUE_DEPTH-entry queue; full is high while it
// is full. The emitter drains eight words for a passing image and one for a failed one,
// one word per cycle through the output register; pop low holds the current word.
// Synchronous active-high reset clears the image state, queue, emitter and csr registers.
module firmware_image_header_builder #(
   parameter int unsigned QUEUE_DEPTH = fwhb_pkg::JOB_QUEUE_DEPTH
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               push,
   output logic                               full,
   input  fwhb_pkg::req_type                  req_data,
   output logic                               empty,
   input  logic                               pop,
   output fwhb_pkg::rsp_type                  rsp_data,
   input  logic                               csr_we,
   input  logic [fwhb_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [31:0]                        csr_wdata
);
   import fwhb_pkg::*;

   cfg_type cfg_ff, cfg_in;
   logic    req_accept;
   logic    job_push, job_pop, job_valid;
   job_type front_job, queue_job;

   // Register writes; unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_MAGIC:      cfg_in.package_magic         = csr_wdata;
            CSR_HDR_VER:    cfg_in.header_format_version = csr_wdata[15:0];
            CSR_APP_VER:    cfg_in.application_version   = csr_wdata;
            CSR_IMAGE_KIND: cfg_in.image_kind            = csr_wdata;
            CSR_LOAD_ADDR:  cfg_in.load_address          = csr_wdata;
            CSR_SIZE_LIMIT: cfg_in.size_limit            = csr_wdata;
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_accept = push & ~full;

   fwhb_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_accept (req_accept),
      .req_data   (req_data),
      .size_limit (cfg_ff.size_limit),
      .job_push   (job_push),
      .job        (front_job)
   );

   fwhb_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push_en  (job_push),
      .push_job (front_job),
      .pop_en   (job_pop),
      .pop_job  (queue_job),
      .q_full   (full),
      .q_valid  (job_valid)
   );

   fwhb_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .job_valid (job_valid),
      .job       (queue_job),
      .job_pop   (job_pop),
      .pop       (pop),
      .empty     (empty),
      .rsp_data  (rsp_data)
   );

endmodule
